/* design/egcd_pkg.sv */
// Shared types and constants for the extended Euclidean gcd unit.
package egcd_pkg;

  localparam int WIDTH      = 32;
  localparam int CNT_W      = $clog2(WIDTH);
  localparam int IN_TDATA_W  = ((2 * WIDTH + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((3 * WIDTH + 7) / 8) * 8;

  typedef logic [WIDTH-1:0] word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_UPDATE,
    ST_DONE
  } egcd_state_t;

  // Sequencer commands to the datapath
  typedef struct packed {
    logic load;
    logic div_init;
    logic div_step;
    logic update;
  } egcd_ctl_t;

  // Datapath status back to the sequencer
  typedef struct packed {
    logic r1_zero;
    logic last_step;
  } egcd_stat_t;

endpackage

/* design/egcd_core.sv */
// Datapath: remainder pair, coefficient pairs and the shared shift-subtract step.
module egcd_core (
  input  logic               clk,
  input  logic               rst,
  input  egcd_pkg::egcd_ctl_t  ctl,
  output egcd_pkg::egcd_stat_t stat,
  input  logic               signed_operands,
  input  egcd_pkg::word_t    operand_a,
  input  egcd_pkg::word_t    operand_b,
  output egcd_pkg::word_t    gcd_value,
  output egcd_pkg::word_t    coef_a,
  output egcd_pkg::word_t    coef_b
);
  import egcd_pkg::*;

  localparam word_t SIGN_BIT = word_t'(1) << (WIDTH - 1);

  // Saturating absolute value
  function automatic word_t magnitude(input word_t v, input logic sgn);
    word_t res;
    if (!sgn || !v[WIDTH-1]) begin
      res = v;
    end else if (v == SIGN_BIT) begin
      res = SIGN_BIT - word_t'(1);
    end else begin
      res = word_t'(0) - v;
    end
    return res;
  endfunction

  // Multiply coefficient by the operand's sign (-1, 0, 1)
  function automatic word_t apply_sign(input word_t coef, input word_t opnd, input logic sgn);
    word_t res;
    if (opnd == '0) begin
      res = '0;
    end else if (sgn && opnd[WIDTH-1]) begin
      res = word_t'(0) - coef;
    end else begin
      res = coef;
    end
    return res;
  endfunction

  word_t r0, r1, x0, x1, y0, y1;
  word_t rem, dvd, px, py;
  word_t a_raw, b_raw;
  logic  sgn;
  logic [CNT_W-1:0] cnt;

  logic [WIDTH:0] trial, diff;
  logic           ge;
  word_t          rem_next;

  // One restoring-division bit; quotient bit also drives the Horner products
  always_comb begin
    trial    = {rem, dvd[WIDTH-1]};
    diff     = trial - {1'b0, r1};
    ge       = (trial >= {1'b0, r1});
    rem_next = ge ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      a_raw <= operand_a;
      b_raw <= operand_b;
      sgn   <= signed_operands;
      r0    <= magnitude(operand_a, signed_operands);
      r1    <= magnitude(operand_b, signed_operands);
      x0    <= word_t'(1);
      x1    <= '0;
      y0    <= '0;
      y1    <= word_t'(1);
    end else if (ctl.div_init) begin
      rem <= '0;
      dvd <= r0;
      px  <= '0;
      py  <= '0;
      cnt <= '0;
    end else if (ctl.div_step) begin
      rem <= rem_next;
      dvd <= {dvd[WIDTH-2:0], 1'b0};
      px  <= {px[WIDTH-2:0], 1'b0} + (ge ? x1 : '0);
      py  <= {py[WIDTH-2:0], 1'b0} + (ge ? y1 : '0);
      cnt <= cnt + CNT_W'(1);
    end else if (ctl.update) begin
      r0 <= r1;
      r1 <= rem;
      x0 <= x1;
      x1 <= x0 - px;
      y0 <= y1;
      y1 <= y0 - py;
    end
  end

  assign stat.r1_zero   = (r1 == '0);
  assign stat.last_step = (cnt == CNT_W'(WIDTH - 1));

  assign gcd_value = r0;
  assign coef_a    = apply_sign(x0, a_raw, sgn);
  assign coef_b    = apply_sign(y0, b_raw, sgn);

  // Partial remainder stays below the divisor
  a_rem_below: assert property (@(posedge clk) disable iff (rst)
    ctl.div_step |-> rem < r1)
    else $error("partial remainder not below divisor");

  // Never start a division by zero
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    ctl.div_init |-> r1 != '0)
    else $error("division started with zero divisor");

  // Each Euclid step shrinks the remainder pair
  a_shrink: assert property (@(posedge clk) disable iff (rst)
    ctl.update |=> r1 < r0)
    else $error("remainder did not shrink");

endmodule

/* design/egcd_ctrl.sv */
// Sequencer: load, per-iteration division sweep, coefficient update, hand-off.
module egcd_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_accept,
  input  logic                 out_free,
  input  egcd_pkg::egcd_stat_t stat,
  output egcd_pkg::egcd_ctl_t  ctl,
  output logic                 in_ready,
  output logic                 out_load
);
  import egcd_pkg::*;

  egcd_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_accept) state_next = ST_CHECK;
      ST_CHECK:  state_next = stat.r1_zero ? ST_DONE : ST_DIV;
      ST_DIV:    if (stat.last_step) state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_CHECK;
      ST_DONE:   if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl      = '0;
    in_ready = 1'b0;
    out_load = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        ctl.load = in_accept;
      end
      ST_CHECK:  ctl.div_init = !stat.r1_zero;
      ST_DIV:    ctl.div_step = 1'b1;
      ST_UPDATE: ctl.update   = 1'b1;
      ST_DONE:   out_load     = out_free;
      default: ;
    endcase
  end

endmodule

/* design/extended_euclid_gcd_unit.sv */
// Top level of the extended Euclidean gcd unit: stream ports, config register, output register.
//
// Takes two WIDTH-bit operands per item and returns gcd(|a|,|b|) with Bezout
// coefficients such that coef_a*a + coef_b*b == gcd (mod 2^WIDTH). The
// signed_operands register (reset 1) selects two's complement or unsigned
// operands; in signed mode the most negative value is taken as 2^(WIDTH-1)-1,
// and a zero operand always gets a zero coefficient. The unit works on one item
// at a time: s_axis_tready is high only while idle. Each Euclid iteration runs
// a bit-serial restoring division, one quotient bit per cycle, and the same
// quotient bits build q*x and q*y by shift-and-add. The number of Euclid
// iterations per item is data dependent: 0 when operand_b is zero, at most
// about 46 for 32-bit operands. The result sits in an output register, so the
// next item can be accepted while it waits.
module extended_euclid_gcd_unit (
  input  logic                             clk,
  input  logic                             rst,
  // config write
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic                             cfg_data,       // signed_operands
  // input items
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [egcd_pkg::IN_TDATA_W-1:0]  s_axis_tdata,   // operand_a, operand_b
  // result items
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [egcd_pkg::OUT_TDATA_W-1:0] m_axis_tdata    // gcd_value, coef_a, coef_b
);
  import egcd_pkg::*;

  logic       signed_operands;
  egcd_ctl_t  ctl;
  egcd_stat_t stat;
  logic       in_accept, out_free, out_load;
  word_t      gcd_value, coef_a, coef_b;
  logic [OUT_TDATA_W-1:0] out_pack;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      signed_operands <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      signed_operands <= cfg_data;
    end
  end

  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign out_free  = !m_axis_tvalid || m_axis_tready;

  egcd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_accept (in_accept),
    .out_free  (out_free),
    .stat      (stat),
    .ctl       (ctl),
    .in_ready  (s_axis_tready),
    .out_load  (out_load)
  );

  egcd_core u_core (
    .clk             (clk),
    .rst             (rst),
    .ctl             (ctl),
    .stat            (stat),
    .signed_operands (signed_operands),
    .operand_a       (s_axis_tdata[WIDTH-1:0]),
    .operand_b       (s_axis_tdata[2*WIDTH-1:WIDTH]),
    .gcd_value       (gcd_value),
    .coef_a          (coef_a),
    .coef_b          (coef_b)
  );

  // Pack fields lowest first, zero fill to whole bytes
  always_comb begin
    out_pack                      = '0;
    out_pack[WIDTH-1:0]           = gcd_value;
    out_pack[2*WIDTH-1:WIDTH]     = coef_a;
    out_pack[3*WIDTH-1:2*WIDTH]   = coef_b;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= out_pack;
    end
  end

  // Busy right after an item is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> !s_axis_tready)
    else $error("ready again right after accept");

  // A result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result register overwritten");

  // Exactly one result per item: loading happens only with no new input taken
  a_load_excl: assert property (@(posedge clk) disable iff (rst)
    out_load |-> !in_accept)
    else $error("result load collides with input accept");

endmodule
